// ===== rtl/bswm_pkg.sv =====
// shared types, constants and helpers for the balanced slot to worker mapper
// no dependencies; imported by bswm_alu, the mapper and the testbench
package bswm_pkg;

    localparam int MAX_SLOTS       = 64;
    localparam int MAX_WORKERS     = 32;
    localparam int SIZE_W          = 32;
    localparam int SLOT_W          = $clog2(MAX_SLOTS);
    localparam int SCNT_W          = $clog2(MAX_SLOTS + 1);
    localparam int WID_W           = $clog2(MAX_WORKERS);
    localparam int WCNT_W          = $clog2(MAX_WORKERS + 1);
    localparam int LOAD_W          = SIZE_W + SLOT_W;
    localparam int ORDER_W         = $clog2(2 * MAX_SLOTS);
    localparam int SHARE_PCT       = 100;
    localparam int LIMIT_PCT       = 103;
    localparam int RESERVE_STEP    = 20;
    localparam int MIN_BAL_WORKERS = 4;
    localparam int MIN_MOVE_SLOTS  = 2;
    localparam int MUL_A_W         = LOAD_W + 1;
    localparam int MUL_B_W         = $clog2(SHARE_PCT * MAX_WORKERS + 1);
    localparam int ALU_W           = MUL_A_W + MUL_B_W;
    localparam int CFG_W           = 6;
    localparam int CFG_IDX_W       = 1;
    localparam int OWN_W           = WID_W + ORDER_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WORKER_COUNT,
        CFG_BALANCE_MODE
    } t_cfg_idx;

    typedef struct packed {
        logic [SIZE_W-1:0] slot_size;
        logic              last_slot;
    } t_in;

    typedef struct packed {
        logic [5:0] slot_index;
        logic [4:0] worker_index;
        logic       last_result;
    } t_out;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL
    } t_alu_op;

    typedef struct packed {
        logic [ALU_W-1:0] result;
        logic             lt;
        logic             eq;
    } t_alu_res;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SORT_KRD,
        ST_SORT_KEY,
        ST_SORT_RD,
        ST_SORT_CMP,
        ST_SORT_WR,
        ST_GR_RK,
        ST_GR_SZ,
        ST_GR_LD,
        ST_GR_SCAN,
        ST_GR_UPD,
        ST_GR_TOT,
        ST_RD_INIT,
        ST_RD_SRC,
        ST_RD_DST,
        ST_RD_PK_RD,
        ST_RD_PK,
        ST_RD_PICK_RD,
        ST_RD_SUM,
        ST_RD_MUL1,
        ST_RD_MUL2,
        ST_RD_CMP,
        ST_RD_MV1,
        ST_RD_MV2,
        ST_OUT_RD,
        ST_OUT_EMIT
    } t_state;

    // reserve workers: floor((w-1)/step)+1, built from compares
    function automatic logic [WCNT_W-1:0] reserve_workers(input logic [WCNT_W-1:0] w);
        logic [WCNT_W-1:0] cnt;
        cnt = WCNT_W'(1);
        for (int k = 1; k <= MAX_WORKERS / RESERVE_STEP; k++) begin
            if (int'(w) - 1 >= k * RESERVE_STEP) begin
                cnt = cnt + WCNT_W'(1);
            end
        end
        return cnt;
    endfunction

endpackage

// ===== rtl/bswm_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module bswm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/bswm_alu.sv =====
// shared arithmetic unit: add, subtract, narrow multiply and magnitude compare
// depends on bswm_pkg
module bswm_alu (
    input  bswm_pkg::t_alu_op            i_op,
    input  logic [bswm_pkg::ALU_W-1:0]   i_a,
    input  logic [bswm_pkg::ALU_W-1:0]   i_b,
    output bswm_pkg::t_alu_res           o_res
);
    import bswm_pkg::*;

    always_comb begin
        o_res.lt = (i_a < i_b);
        o_res.eq = (i_a == i_b);
        unique case (i_op)
            ALU_ADD: o_res.result = i_a + i_b;
            ALU_SUB: o_res.result = i_a - i_b;
            ALU_MUL: o_res.result = ALU_W'(i_a[MUL_A_W-1:0] * i_b[MUL_B_W-1:0]);
            default: o_res.result = '0;
        endcase
    end
endmodule

// ===== rtl/balanced_slot_to_worker_mapper.sv =====
// order of work: rank sort of the slots and greedy placement, then redistribution
// rounds when reserve workers are in use, then the result words out
// throughput: one set at a time; slot words before the last take one cycle each
// busy stays high from the last slot word until the final result word; the shared alu
// and slot ram read port serialise the work. sync active-low reset clears control and
// balance mode, sets worker count to 1; results cannot be held off by the receiver
module balanced_slot_to_worker_mapper (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  bswm_pkg::t_in                    i_in,
    output logic                             o_strobe,
    output bswm_pkg::t_out                   o_out,
    input  logic                             i_cfg_we,
    input  logic [bswm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [bswm_pkg::CFG_W-1:0]       i_cfg_data
);
    import bswm_pkg::*;

    t_state r_state, n_state;

    logic [CFG_W-1:0]   r_wcount_cfg;
    logic               r_bal_cfg;
    logic [SCNT_W-1:0]  r_slot_count, n_slot_count;
    logic [SCNT_W-1:0]  r_n, n_n;
    logic [WCNT_W-1:0]  r_w, n_w, r_base, n_base;
    logic               r_resv, n_resv;
    logic [MUL_B_W-1:0] r_wscale, n_wscale;
    logic [SCNT_W-1:0]  r_s, n_s, r_t, n_t;
    logic [WCNT_W-1:0]  r_i, n_i;
    logic [SLOT_W-1:0]  r_cnt, n_cnt, r_slot, n_slot, r_pick, n_pick;
    logic [SIZE_W-1:0]  r_key, n_key;
    logic [WID_W-1:0]   r_best, n_best, r_src, n_src, r_dst, n_dst;
    logic [LOAD_W-1:0]  r_bl, n_bl, r_sl, n_sl, r_dl, n_dl, r_total, n_total;
    logic               r_fv, n_fv, r_pv, n_pv;
    logic [ORDER_W-1:0] r_porder, n_porder, r_seq, n_seq;
    logic [ALU_W-1:0]   r_acc, n_acc, r_acc2, n_acc2;

    logic [LOAD_W-1:0]      r_load [MAX_WORKERS];
    logic [SCNT_W-1:0]      r_wcnt [MAX_WORKERS];
    logic [MAX_WORKERS-1:0] r_final;

    // memory ports
    logic [SIZE_W-1:0]  size_rd;
    logic [SLOT_W-1:0]  size_raddr;
    logic               size_we;
    logic [SLOT_W-1:0]  rank_rd;
    logic               rank_we;
    logic [OWN_W-1:0]   own_rd, own_wdata;
    logic [SLOT_W-1:0]  own_waddr;
    logic               own_we;

    t_alu_op           alu_op;
    logic [ALU_W-1:0]  alu_a, alu_b;
    t_alu_res          alu_res;
    logic              alu_gt;

    logic              w_acc, w_clear;
    logic [LOAD_W-1:0] w_load_i;
    logic [WCNT_W-1:0] w_weff;
    logic              w_sort_last, w_slot_last, w_before;
    logic [WID_W-1:0]  own_worker;
    logic [ORDER_W-1:0] own_order;

    // worker array update controls
    logic              ld_we;
    logic [WID_W-1:0]  ld_waddr;
    logic [LOAD_W-1:0] ld_wdata;
    logic              cnt_inc, cnt_dec, fin_set;
    logic [WID_W-1:0]  cnt_addr;

    assign w_acc       = start && !busy;
    assign w_load_i    = r_load[r_i[WID_W-1:0]];
    assign w_sort_last = (r_t == r_n - 1'b1);
    assign w_slot_last = (r_s == r_n - 1'b1);
    assign alu_gt      = !alu_res.lt && !alu_res.eq;
    assign w_before    = alu_gt || (alu_res.eq && (r_t < r_s));
    assign own_worker  = own_rd[OWN_W-1:ORDER_W];
    assign own_order   = own_rd[ORDER_W-1:0];
    assign size_we     = w_acc && (r_slot_count < SCNT_W'(MAX_SLOTS));

    always_comb begin
        if (r_wcount_cfg == '0) begin
            w_weff = WCNT_W'(1);
        end else if (r_wcount_cfg > CFG_W'(MAX_WORKERS)) begin
            w_weff = WCNT_W'(MAX_WORKERS);
        end else begin
            w_weff = WCNT_W'(r_wcount_cfg);
        end
    end

    bswm_ram #(.WIDTH(SIZE_W), .DEPTH(MAX_SLOTS)) u_size_ram (
        .i_clk   (i_clk),
        .i_we    (size_we),
        .i_waddr (r_slot_count[SLOT_W-1:0]),
        .i_wdata (i_in.slot_size),
        .i_raddr (size_raddr),
        .o_rdata (size_rd)
    );

    bswm_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_SLOTS)) u_rank_ram (
        .i_clk   (i_clk),
        .i_we    (rank_we),
        .i_waddr (r_cnt),
        .i_wdata (r_s[SLOT_W-1:0]),
        .i_raddr (r_s[SLOT_W-1:0]),
        .o_rdata (rank_rd)
    );

    bswm_ram #(.WIDTH(OWN_W), .DEPTH(MAX_SLOTS)) u_own_ram (
        .i_clk   (i_clk),
        .i_we    (own_we),
        .i_waddr (own_waddr),
        .i_wdata (own_wdata),
        .i_raddr (r_t[SLOT_W-1:0]),
        .o_rdata (own_rd)
    );

    bswm_alu u_alu (
        .i_op  (alu_op),
        .i_a   (alu_a),
        .i_b   (alu_b),
        .o_res (alu_res)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:       if (w_acc && i_in.last_slot) n_state = ST_SORT_KRD;
            ST_SORT_KRD:   n_state = ST_SORT_KEY;
            ST_SORT_KEY:   n_state = ST_SORT_RD;
            ST_SORT_RD:    n_state = ST_SORT_CMP;
            ST_SORT_CMP:   n_state = w_sort_last ? ST_SORT_WR : ST_SORT_RD;
            ST_SORT_WR:    n_state = w_slot_last ? ST_GR_RK : ST_SORT_KRD;
            ST_GR_RK:      n_state = ST_GR_SZ;
            ST_GR_SZ:      n_state = ST_GR_LD;
            ST_GR_LD:      n_state = ST_GR_SCAN;
            ST_GR_SCAN:    if (r_i >= r_base) n_state = ST_GR_UPD;
            ST_GR_UPD:     n_state = ST_GR_TOT;
            ST_GR_TOT: begin
                if (!w_slot_last) n_state = ST_GR_RK;
                else n_state = r_resv ? ST_RD_INIT : ST_OUT_RD;
            end
            ST_RD_INIT:    n_state = ST_RD_SRC;
            ST_RD_SRC: begin
                if (r_i >= r_base) n_state = r_fv ? ST_RD_DST : ST_OUT_RD;
            end
            ST_RD_DST: begin
                if (r_i >= r_w) begin
                    n_state = (r_wcnt[r_src] < SCNT_W'(MIN_MOVE_SLOTS)) ? ST_RD_INIT
                                                                         : ST_RD_PK_RD;
                end
            end
            ST_RD_PK_RD:   n_state = ST_RD_PK;
            ST_RD_PK:      n_state = w_sort_last ? ST_RD_PICK_RD : ST_RD_PK_RD;
            ST_RD_PICK_RD: n_state = r_pv ? ST_RD_SUM : ST_RD_INIT;
            ST_RD_SUM:     n_state = ST_RD_MUL1;
            ST_RD_MUL1:    n_state = ST_RD_MUL2;
            ST_RD_MUL2:    n_state = ST_RD_CMP;
            ST_RD_CMP:     n_state = alu_gt ? ST_RD_INIT : ST_RD_MV1;
            ST_RD_MV1:     n_state = ST_RD_MV2;
            ST_RD_MV2:     n_state = ST_RD_INIT;
            ST_OUT_RD:     n_state = ST_OUT_EMIT;
            ST_OUT_EMIT:   n_state = w_sort_last ? ST_IDLE : ST_OUT_RD;
            default:       n_state = ST_IDLE;
        endcase
    end

    // outputs and unit controls
    always_comb begin
        busy       = (r_state != ST_IDLE);
        o_strobe   = (r_state == ST_OUT_EMIT);
        o_out.slot_index   = 6'(r_t);
        o_out.worker_index = 5'(own_worker);
        o_out.last_result  = w_sort_last;
        alu_op     = ALU_ADD;
        alu_a      = '0;
        alu_b      = '0;
        size_raddr = r_t[SLOT_W-1:0];
        rank_we    = 1'b0;
        own_we     = 1'b0;
        own_waddr  = r_slot;
        own_wdata  = {r_best, r_seq};
        unique case (r_state)
            ST_SORT_KRD:   size_raddr = r_s[SLOT_W-1:0];
            ST_SORT_CMP: begin
                alu_a = ALU_W'(size_rd);
                alu_b = ALU_W'(r_key);
            end
            ST_SORT_WR:    rank_we = 1'b1;
            ST_GR_SZ:      size_raddr = rank_rd;
            ST_GR_SCAN: begin
                alu_a = ALU_W'(w_load_i);
                alu_b = ALU_W'(r_bl);
            end
            ST_GR_UPD: begin
                alu_a  = ALU_W'(r_bl);
                alu_b  = ALU_W'(r_key);
                own_we = 1'b1;
            end
            ST_GR_TOT: begin
                alu_a = ALU_W'(r_total);
                alu_b = ALU_W'(r_key);
            end
            ST_RD_SRC: begin
                alu_a = ALU_W'(w_load_i);
                alu_b = ALU_W'(r_sl);
            end
            ST_RD_DST: begin
                alu_a = ALU_W'(w_load_i);
                alu_b = ALU_W'(r_dl);
            end
            ST_RD_PICK_RD: size_raddr = r_pick;
            ST_RD_SUM: begin
                alu_a = ALU_W'(r_dl);
                alu_b = ALU_W'(size_rd);
            end
            ST_RD_MUL1: begin
                alu_op = ALU_MUL;
                alu_a  = r_acc;
                alu_b  = ALU_W'(r_wscale);
            end
            ST_RD_MUL2: begin
                alu_op = ALU_MUL;
                alu_a  = ALU_W'(r_total);
                alu_b  = ALU_W'(LIMIT_PCT);
            end
            ST_RD_CMP: begin
                alu_a = r_acc;
                alu_b = r_acc2;
            end
            ST_RD_MV1: begin
                alu_op    = ALU_SUB;
                alu_a     = ALU_W'(r_sl);
                alu_b     = ALU_W'(r_key);
                own_we    = 1'b1;
                own_waddr = r_pick;
                own_wdata = {r_dst, r_seq};
            end
            ST_RD_MV2: begin
                alu_a = ALU_W'(r_dl);
                alu_b = ALU_W'(r_key);
            end
            default: ;
        endcase
    end

    // datapath next values
    always_comb begin
        n_slot_count = r_slot_count;
        n_n = r_n;  n_w = r_w;  n_base = r_base;  n_resv = r_resv;  n_wscale = r_wscale;
        n_s = r_s;  n_t = r_t;  n_i = r_i;  n_cnt = r_cnt;  n_slot = r_slot;
        n_pick = r_pick;  n_key = r_key;  n_best = r_best;  n_src = r_src;  n_dst = r_dst;
        n_bl = r_bl;  n_sl = r_sl;  n_dl = r_dl;  n_total = r_total;  n_fv = r_fv;
        n_pv = r_pv;  n_porder = r_porder;  n_seq = r_seq;  n_acc = r_acc;  n_acc2 = r_acc2;
        w_clear  = 1'b0;
        ld_we    = 1'b0;
        ld_waddr = r_best;
        ld_wdata = LOAD_W'(alu_res.result);
        cnt_inc  = 1'b0;
        cnt_dec  = 1'b0;
        cnt_addr = r_best;
        fin_set  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    n_slot_count = size_we ? r_slot_count + 1'b1 : r_slot_count;
                    if (i_in.last_slot) begin
                        n_n      = n_slot_count;
                        n_w      = w_weff;
                        n_resv   = r_bal_cfg && (w_weff >= WCNT_W'(MIN_BAL_WORKERS));
                        n_base   = n_resv ? w_weff - reserve_workers(w_weff) : w_weff;
                        n_wscale = MUL_B_W'(int'(w_weff) * SHARE_PCT);
                        n_s      = '0;
                        n_seq    = '0;
                        n_total  = '0;
                        w_clear  = 1'b1;
                    end
                end
            end
            ST_SORT_KEY: begin
                n_key = size_rd;
                n_t   = '0;
                n_cnt = '0;
            end
            ST_SORT_CMP: begin
                if (w_before) n_cnt = r_cnt + 1'b1;
                n_t = r_t + 1'b1;
            end
            ST_SORT_WR:    n_s = w_slot_last ? '0 : r_s + 1'b1;
            ST_GR_SZ:      n_slot = rank_rd;
            ST_GR_LD: begin
                n_key = size_rd;
                n_i   = '0;
                n_fv  = 1'b0;
            end
            ST_GR_SCAN: begin
                if (r_i < r_base) begin
                    if (!r_fv || alu_res.lt) begin
                        n_best = r_i[WID_W-1:0];
                        n_bl   = w_load_i;
                        n_fv   = 1'b1;
                    end
                    n_i = r_i + 1'b1;
                end
            end
            ST_GR_UPD: begin
                ld_we   = 1'b1;
                cnt_inc = 1'b1;
                n_seq   = r_seq + 1'b1;
            end
            ST_GR_TOT: begin
                n_total = LOAD_W'(alu_res.result);
                n_s     = r_s + 1'b1;
                n_t     = '0;
            end
            ST_RD_INIT: begin
                n_i  = '0;
                n_fv = 1'b0;
            end
            ST_RD_SRC: begin
                if (r_i < r_base) begin
                    if (!r_final[r_i[WID_W-1:0]] && (!r_fv || alu_gt)) begin
                        n_src = r_i[WID_W-1:0];
                        n_sl  = w_load_i;
                        n_fv  = 1'b1;
                    end
                    n_i = r_i + 1'b1;
                end else begin
                    n_i  = r_base;
                    n_fv = 1'b0;
                    n_t  = '0;
                end
            end
            ST_RD_DST: begin
                if (r_i < r_w) begin
                    if (!r_fv || alu_res.lt) begin
                        n_dst = r_i[WID_W-1:0];
                        n_dl  = w_load_i;
                        n_fv  = 1'b1;
                    end
                    n_i = r_i + 1'b1;
                end else if (r_wcnt[r_src] < SCNT_W'(MIN_MOVE_SLOTS)) begin
                    fin_set = 1'b1;
                end else begin
                    n_t  = '0;
                    n_pv = 1'b0;
                end
            end
            ST_RD_PK: begin
                if (own_worker == r_src && (!r_pv || own_order > r_porder)) begin
                    n_pick   = r_t[SLOT_W-1:0];
                    n_porder = own_order;
                    n_pv     = 1'b1;
                end
                n_t = r_t + 1'b1;
            end
            ST_RD_PICK_RD: if (!r_pv) fin_set = 1'b1;
            ST_RD_SUM: begin
                n_acc = alu_res.result;
                n_key = size_rd;
            end
            ST_RD_MUL1:    n_acc  = alu_res.result;
            ST_RD_MUL2:    n_acc2 = alu_res.result;
            ST_RD_CMP:     if (alu_gt) fin_set = 1'b1;
            ST_RD_MV1: begin
                ld_we    = 1'b1;
                ld_waddr = r_src;
                cnt_dec  = 1'b1;
                cnt_addr = r_src;
                n_seq    = r_seq + 1'b1;
            end
            ST_RD_MV2: begin
                ld_we    = 1'b1;
                ld_waddr = r_dst;
                cnt_inc  = 1'b1;
                cnt_addr = r_dst;
                n_t      = '0;
            end
            ST_OUT_EMIT: begin
                n_t = r_t + 1'b1;
                if (w_sort_last) n_slot_count = '0;
            end
            default: ;
        endcase
        // the source pick scan and the output pass both start the slot counter at zero
        if (r_state == ST_RD_SRC && r_i >= r_base && !r_fv) n_t = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_slot_count <= '0;
            r_wcount_cfg <= CFG_W'(1);
            r_bal_cfg    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_slot_count <= n_slot_count;
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_WORKER_COUNT: r_wcount_cfg <= i_cfg_data;
                    CFG_BALANCE_MODE: r_bal_cfg    <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_n <= n_n;  r_w <= n_w;  r_base <= n_base;  r_resv <= n_resv;  r_wscale <= n_wscale;
        r_s <= n_s;  r_t <= n_t;  r_i <= n_i;  r_cnt <= n_cnt;  r_slot <= n_slot;
        r_pick <= n_pick;  r_key <= n_key;  r_best <= n_best;  r_src <= n_src;
        r_dst <= n_dst;  r_bl <= n_bl;  r_sl <= n_sl;  r_dl <= n_dl;  r_total <= n_total;
        r_fv <= n_fv;  r_pv <= n_pv;  r_porder <= n_porder;  r_seq <= n_seq;
        r_acc <= n_acc;  r_acc2 <= n_acc2;
    end

    // per-worker load, slot count and final flag
    always_ff @(posedge i_clk) begin
        if (w_clear) begin
            for (int k = 0; k < MAX_WORKERS; k++) begin
                r_load[k] <= '0;
                r_wcnt[k] <= '0;
            end
            r_final <= '0;
        end else begin
            if (ld_we) r_load[ld_waddr] <= ld_wdata;
            if (cnt_inc) r_wcnt[cnt_addr] <= r_wcnt[cnt_addr] + 1'b1;
            if (cnt_dec) r_wcnt[cnt_addr] <= r_wcnt[cnt_addr] - 1'b1;
            if (fin_set) r_final[r_src] <= 1'b1;
        end
    end

    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy) else $error("result word outside a mapping pass");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_in.last_slot) |=> busy) else $error("last slot did not start mapping");
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_out.last_result) |=> (!busy && r_slot_count == '0))
        else $error("block not idle after final word");
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot_count <= SCNT_W'(MAX_SLOTS)) else $error("slot count beyond capacity");
endmodule

// ===== tb/balanced_slot_to_worker_mapper_tb.sv =====
// testbench for the balanced slot to worker mapper: drives slot sets, predicts the mapping
// with its own longest-first placement and redistribution, checks every result word
// depends on bswm_pkg and rtl/balanced_slot_to_worker_mapper.sv
class mapping_board;
    bswm_pkg::t_out pending[$];
    int errors;

    function void note_input(bswm_pkg::t_out w);
        pending = {pending, w};
    endfunction

    function void check_result(bswm_pkg::t_out got);
        bswm_pkg::t_out exp_w;
        if (pending.size() == 0) begin
            $error("result word with nothing expected: %h", got);
            errors++;
            return;
        end
        exp_w = pending.pop_front();
        if (got.slot_index !== exp_w.slot_index) begin
            $error("slot_index expected %0d actual %0d", exp_w.slot_index, got.slot_index);
            errors++;
        end
        if (got.worker_index !== exp_w.worker_index) begin
            $error("worker_index expected %0d actual %0d", exp_w.worker_index,
                   got.worker_index);
            errors++;
        end
        if (got.last_result !== exp_w.last_result) begin
            $error("last_result expected %0d actual %0d", exp_w.last_result,
                   got.last_result);
            errors++;
        end
    endfunction
endclass

module balanced_slot_to_worker_mapper_tb;
    import bswm_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_in i_in = '0;
    logic o_strobe;
    t_out o_out;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0] i_cfg_data = '0;

    mapping_board board = new();

    // predictor state
    int unsigned m_workers = 1;
    int unsigned m_balance = 0;
    logic [31:0] m_size[MAX_SLOTS];
    int unsigned m_count = 0;
    bit no_idle = 1'b0;
    int cycles = 0;

    balanced_slot_to_worker_mapper i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_in(i_in), .o_strobe(o_strobe), .o_out(o_out),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && o_strobe) board.check_result(o_out);
        if (cycles > CYCLE_LIMIT) begin
            $display("balanced_slot_to_worker_mapper_tb: FAIL");
            $finish;
        end
    end

    function automatic void map_set();
        int unsigned w, reserve, nbase, n, seq, best, src, dst, pick, k, i, j, s;
        int unsigned rank[MAX_SLOTS];
        int unsigned owner[MAX_SLOTS];
        int unsigned order[MAX_SLOTS];
        longint unsigned load[MAX_WORKERS];
        int unsigned cnt[MAX_WORKERS];
        bit fin[MAX_WORKERS];
        longint unsigned total;
        t_out r;
        n = m_count;
        w = m_workers;
        if (w == 0) w = 1;
        if (w > MAX_WORKERS) w = MAX_WORKERS;
        reserve = (m_balance != 0 && w >= 4) ? (w - 1) / 20 + 1 : 0;
        nbase = w - reserve;
        seq = 0;
        total = 0;
        for (i = 0; i < MAX_WORKERS; i++) begin
            load[i] = 0; cnt[i] = 0; fin[i] = 0;
        end
        for (i = 0; i < n; i++) begin
            j = i;
            while (j > 0 && (m_size[i] > m_size[rank[j-1]] ||
                   (m_size[i] == m_size[rank[j-1]] && i < rank[j-1]))) begin
                rank[j] = rank[j-1];
                j--;
            end
            rank[j] = i;
        end
        for (k = 0; k < n; k++) begin
            s = rank[k];
            best = 0;
            for (i = 1; i < nbase; i++) if (load[i] < load[best]) best = i;
            owner[s] = best;
            order[s] = seq++;
            load[best] += m_size[s];
            cnt[best]++;
            total += m_size[s];
        end
        if (reserve != 0) begin
            forever begin
                src = MAX_WORKERS; dst = nbase; pick = MAX_SLOTS;
                for (i = 0; i < nbase; i++)
                    if (!fin[i] && (src == MAX_WORKERS || load[i] > load[src])) src = i;
                if (src == MAX_WORKERS) break;
                for (i = nbase + 1; i < w; i++) if (load[i] < load[dst]) dst = i;
                if (cnt[src] < 2) begin
                    fin[src] = 1;
                    continue;
                end
                for (i = 0; i < n; i++)
                    if (owner[i] == src && (pick == MAX_SLOTS || order[i] > order[pick]))
                        pick = i;
                if (pick == MAX_SLOTS ||
                    64'd100 * w * (load[dst] + m_size[pick]) > 64'd103 * total) begin
                    fin[src] = 1;
                    continue;
                end
                owner[pick] = dst;
                order[pick] = seq++;
                load[src] -= m_size[pick];
                load[dst] += m_size[pick];
                cnt[src]--;
                cnt[dst]++;
            end
        end
        for (i = 0; i < n; i++) begin
            r.slot_index = 6'(i);
            r.worker_index = 5'(owner[i]);
            r.last_result = (i + 1 == n);
            board.note_input(r);
        end
        m_count = 0;
    endfunction

    task automatic write_reg(t_cfg_idx idx, int unsigned val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= CFG_W'(val);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        if (idx == CFG_WORKER_COUNT) m_workers = val & 6'h3f;
        else m_balance = val & 1;
    endtask

    // start stays high between words of a set unless an idle gap is drawn
    task automatic send_word(logic [31:0] sz, bit last);
        if (!no_idle) begin
            while ($urandom_range(99) < 24) begin
                start <= 1'b0;
                @(posedge i_clk);
            end
        end
        start <= 1'b1;
        i_in <= '{slot_size: sz, last_slot: last};
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (last) start <= 1'b0;
        if (m_count < MAX_SLOTS) begin
            m_size[m_count] = sz;
            m_count++;
        end
        if (last) map_set();
    endtask

    task automatic drain();
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_size(int unsigned kind);
        case (kind)
            0: return $urandom_range(15);
            1: return $urandom_range(1000);
            2: return 32'hffffffff - $urandom_range(3);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_set(int unsigned n, int unsigned kind);
        for (int i = 0; i < n; i++) send_word(rand_size(kind), i == n - 1);
    endtask

    initial begin
        int unsigned sent;
        int unsigned n;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: single slot, extremes, ties, overflow past the slot store
        write_reg(CFG_WORKER_COUNT, 1);
        write_reg(CFG_BALANCE_MODE, 0);
        send_word(32'hffffffff, 1'b1);
        drain();
        write_reg(CFG_WORKER_COUNT, 0);
        send_word(32'd0, 1'b0);
        send_word(32'd0, 1'b1);
        drain();
        write_reg(CFG_WORKER_COUNT, 32);
        write_reg(CFG_BALANCE_MODE, 1);
        send_word(32'h80000000, 1'b0);
        send_word(32'h7fffffff, 1'b0);
        send_word(32'h7fffffff, 1'b0);
        send_word(32'd1, 1'b1);
        drain();
        write_reg(CFG_WORKER_COUNT, 63);
        send_word(32'd5, 1'b0);
        send_word(32'd9, 1'b1);
        drain();
        write_reg(CFG_WORKER_COUNT, 4);
        for (int i = 0; i < 8; i++) send_word(32'd10, 1'b0);
        send_word(32'd3, 1'b1);
        drain();
        write_reg(CFG_WORKER_COUNT, 3);
        no_idle = 1'b1;
        for (int i = 0; i < 66; i++) send_word($urandom_range(50), i == 65);
        drain();
        no_idle = 1'b0;

        // random sets, small mostly, occasionally large (30 to 64 slots)
        sent = 0;
        while (sent < 120) begin
            write_reg(CFG_WORKER_COUNT, $urandom_range(1, 32));
            write_reg(CFG_BALANCE_MODE, $urandom_range(1));
            n = ($urandom_range(9) == 0) ? $urandom_range(30, 64) : $urandom_range(1, 8);
            no_idle = (sent >= 40 && sent < 80);
            send_set(n, $urandom_range(3));
            sent += n;
            drain();
        end
        drain();
        if (board.errors == 0 && board.pending.size() == 0)
            $display("balanced_slot_to_worker_mapper_tb: PASS");
        else
            $display("balanced_slot_to_worker_mapper_tb: FAIL");
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/bswm_pkg.sv
rtl/bswm_ram.sv
rtl/bswm_alu.sv
rtl/balanced_slot_to_worker_mapper.sv
tb/balanced_slot_to_worker_mapper_tb.sv
